// File: design/wifs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wifs_pkg;

    localparam int MAX_SOURCES_DEF     = 8;
    localparam int GRID_COLS_DEF       = 512;
    localparam int GRID_ROWS_DEF       = 128;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int IDX_W      = 4;   // source index, enough for the largest table
    localparam int DIV_STEPS  = 22;  // restoring divider, one quotient bit a cycle
    localparam int SQRT_STEPS = 18;  // root bits of a 36-bit radicand
    localparam int CNT_W      = 5;

    // word kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam logic [5:0]  LAMBDA_LO   = 6'd6;
    localparam logic [5:0]  LAMBDA_HI   = 6'd60;
    localparam logic [21:0] WAVE_NUMER  = 22'h200000;  // 2^21
    localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic             in_ready;
        logic             div_step;
        logic             wstore;
        logic             sq;
        logic             sumsq;
        logic             sqrt_step;
        logic             mul;
        logic             look;
        logic             acc;
        logic             nload;
        logic             fin;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic kind;
        logic write_go;
        logic in_grid;
        logic cur_active;
        logic out_busy;
    } t_status;

    // Quarter-wave entry, Q30 Taylor polynomial of degree 11, rounded to Q1.14.
    function automatic logic [14:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (HALF_PI_Q30 * 64'(i)) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s * 64'd16384 + 64'h2000_0000) >> 30;
        if (v > 64'd16384) begin
            v = 64'd16384;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

// File: design/wifs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wifs_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [2:0]         slot;
    logic               enable;
    logic [12:0]        source_x;
    logic [10:0]        source_y;
    logic signed [15:0] angular_rate;
    logic [5:0]         wavelength;
    logic [15:0]        start_phase;
    logic [6:0]         row;
    logic [8:0]         col;
    logic [23:0]        time_req;

    modport source (output valid, kind, slot, enable, source_x, source_y, angular_rate,
                    wavelength, start_phase, row, col, time_req, input ready);
    modport sink (input valid, kind, slot, enable, source_x, source_y, angular_rate,
                  wavelength, start_phase, row, col, time_req, output ready);
endinterface

interface wifs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] amplitude;
    logic               blank;
    logic               negative;
    logic [1:0]         level;

    modport source (output valid, amplitude, blank, negative, level, input ready);
    modport sink (input valid, amplitude, blank, negative, level, output ready);
endinterface

`default_nettype wire

// File: design/wifs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wifs_ctrl #(
    parameter int MAX_SOURCES = wifs_pkg::MAX_SOURCES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wifs_pkg::t_status i_status,
    output wifs_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIVW   = 4'd1;
    localparam logic [3:0] S_WSTORE = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_SUMSQ  = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_LOOK   = 4'd8;
    localparam logic [3:0] S_ACC    = 4'd9;
    localparam logic [3:0] S_NLOAD  = 4'd10;
    localparam logic [3:0] S_NDIV   = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    localparam logic [wifs_pkg::IDX_W-1:0] LAST_IDX = wifs_pkg::IDX_W'(MAX_SOURCES - 1);
    localparam logic [wifs_pkg::CNT_W-1:0] DIV_LAST = wifs_pkg::CNT_W'(wifs_pkg::DIV_STEPS - 1);
    localparam logic [wifs_pkg::CNT_W-1:0] SQRT_LAST =
        wifs_pkg::CNT_W'(wifs_pkg::SQRT_STEPS - 1);

    logic [3:0]                 r_state, n_state;
    logic [wifs_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [wifs_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                n_cnt = '0;
                n_idx = '0;
                if (i_status.in_valid) begin
                    if (i_status.kind == wifs_pkg::KIND_WRITE) begin
                        n_state = i_status.write_go ? S_DIVW : S_IDLE;
                    end else begin
                        n_state = i_status.in_grid ? S_CHECK : S_NLOAD;
                    end
                end
            end
            S_DIVW: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_WSTORE;
                end
            end
            S_WSTORE: begin
                o_cmd.wstore = 1'b1;
                n_state = S_IDLE;
            end
            S_CHECK: begin
                if (i_status.cur_active) begin
                    n_state = S_SQ;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_NLOAD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = S_SUMSQ;
            end
            S_SUMSQ: begin
                o_cmd.sumsq = 1'b1;
                n_cnt = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_NLOAD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_NLOAD: begin
                o_cmd.nload = 1'b1;
                n_cnt = '0;
                n_state = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_sqrt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_cnt <= SQRT_LAST))
        else $error("sqrt step count overrun");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= LAST_IDX))
        else $error("source index beyond table");
    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NLOAD) |=> (r_state == S_NDIV && r_cnt == '0))
        else $error("normalize divide not started cleanly");
`endif

endmodule

`default_nettype wire

// File: design/wifs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module wifs_dp #(
    parameter int MAX_SOURCES     = wifs_pkg::MAX_SOURCES_DEF,
    parameter int GRID_COLS       = wifs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS       = wifs_pkg::GRID_ROWS_DEF,
    parameter int SINE_TABLE_BITS = wifs_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    wifs_in_if.sink           i_in,
    wifs_out_if.source        o_out,
    input  wifs_pkg::t_cmd    i_cmd,
    output wifs_pkg::t_status o_status
);

    localparam int SW      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CW      = $clog2(MAX_SOURCES + 1);
    localparam int B       = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (B - 2);

    // quarter-wave table, built at elaboration
    logic [14:0] w_tab [QUARTER + 1];
    for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
        assign w_tab[g] = wifs_pkg::sine_entry(g, B);
    end

    // source table
    logic          r_active [MAX_SOURCES];
    logic [12:0]   r_px     [MAX_SOURCES];
    logic [10:0]   r_py     [MAX_SOURCES];
    logic [15:0]   r_rate   [MAX_SOURCES];
    logic [18:0]   r_wn     [MAX_SOURCES];
    logic [15:0]   r_phase  [MAX_SOURCES];
    logic [CW-1:0] r_count;

    // latched word
    logic [2:0]  r_slot;
    logic [12:0] r_x;
    logic [10:0] r_y;
    logic [15:0] r_rate_in;
    logic [15:0] r_phase_in;
    logic [6:0]  r_row;
    logic [8:0]  r_col;
    logic [23:0] r_time;

    // working registers
    logic [27:0]        r_dx2, r_dy2;
    logic [15:0]        r_wt;
    logic [35:0]        r_rem, r_res, r_bit;
    logic [15:0]        r_kp;
    logic [14:0]        r_tabv;
    logic               r_tneg;
    logic signed [19:0] r_sum;
    logic               r_sum_neg;
    logic [21:0]        r_dq;
    logic [5:0]         r_drem;
    logic [5:0]         r_dvs;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_amp;
    logic               r_blank;
    logic               r_neg;
    logic [1:0]         r_level;
    logic [14:0]        r_mag;

    logic accept;
    logic slot_ok;
    logic [SW-1:0] cur;
    logic [SW-1:0] in_slot;
    logic [SW-1:0] w_slot;
    logic [5:0] lam;

    assign accept  = i_in.valid && i_cmd.in_ready;
    assign slot_ok = ({2'b0, i_in.slot} < 5'(MAX_SOURCES));
    assign cur     = i_cmd.idx[SW-1:0];
    assign in_slot = SW'(i_in.slot);
    assign w_slot  = SW'(r_slot);
    assign i_in.ready = i_cmd.in_ready;

    always_comb begin
        lam = i_in.wavelength;
        if (lam < wifs_pkg::LAMBDA_LO) begin
            lam = wifs_pkg::LAMBDA_LO;
        end else if (lam > wifs_pkg::LAMBDA_HI) begin
            lam = wifs_pkg::LAMBDA_HI;
        end
    end

    assign o_status.in_valid   = i_in.valid;
    assign o_status.kind       = i_in.kind;
    assign o_status.write_go   = slot_ok && i_in.enable;
    assign o_status.in_grid    = ({3'b0, i_in.row} < 10'(GRID_ROWS)) &&
                                 ({2'b0, i_in.col} < 11'(GRID_COLS));
    assign o_status.cur_active = r_active[cur];
    assign o_status.out_busy   = r_out_valid && !o_out.ready;

    // distance terms
    logic signed [14:0] dx;
    logic signed [12:0] dy;
    logic signed [29:0] dx2_p;
    logic signed [25:0] dy2_p;
    logic signed [40:0] wt_p;
    assign dx    = $signed({1'b0, r_col, 4'b0}) - $signed({2'b0, r_px[cur]});
    assign dy    = ($signed({2'b0, r_row, 4'b0}) - $signed({2'b0, r_py[cur]})) <<< 1;
    assign dx2_p = dx * dx;
    assign dy2_p = dy * dy;
    assign wt_p  = $signed(r_rate[cur]) * $signed({1'b0, r_time});

    // one root bit per step
    logic [35:0] trial;
    assign trial = r_res + r_bit;

    logic [36:0] kp_p;
    assign kp_p = r_res[17:0] * r_wn[cur];

    // sine lookup
    logic [15:0]  angle;
    logic [B-1:0] tidx;
    logic [B-2:0] taddr;
    assign angle = r_wt - r_kp + r_phase[cur];
    assign tidx  = angle[15 -: B];
    assign taddr = tidx[B-2] ? ((B-1)'(QUARTER) - {1'b0, tidx[B-3:0]})
                             : {1'b0, tidx[B-3:0]};

    // restoring divide step
    logic [6:0] drem2;
    assign drem2 = {r_drem, r_dq[21]};

    logic [19:0] abs_sum;
    assign abs_sum = r_sum[19] ? 20'(-r_sum) : 20'(r_sum);

    logic [14:0] mag;
    logic [19:0] mag25;
    assign mag   = r_dq[14:0];
    assign mag25 = 20'(mag) * 20'd25;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SOURCES; s++) begin
                r_active[s] <= 1'b0;
            end
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (i_in.kind == wifs_pkg::KIND_WRITE) && slot_ok && !i_in.enable &&
                r_active[in_slot]) begin
                r_active[in_slot] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.wstore && !r_active[w_slot]) begin
                r_active[w_slot] <= 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot     <= i_in.slot;
            r_x        <= i_in.source_x;
            r_y        <= i_in.source_y;
            r_rate_in  <= i_in.angular_rate;
            r_phase_in <= i_in.start_phase;
            r_row      <= i_in.row;
            r_col      <= i_in.col;
            r_time     <= i_in.time_req;
            r_sum      <= '0;
            r_dq       <= wifs_pkg::WAVE_NUMER;
            r_drem     <= '0;
            r_dvs      <= lam;
        end
        if (i_cmd.wstore) begin
            r_px[w_slot]    <= r_x;
            r_py[w_slot]    <= r_y;
            r_rate[w_slot]  <= r_rate_in;
            r_wn[w_slot]    <= r_dq[18:0];
            r_phase[w_slot] <= r_phase_in;
        end
        if (i_cmd.sq) begin
            r_dx2 <= dx2_p[27:0];
            r_dy2 <= 28'(dy2_p[24:0]);
            r_wt  <= wt_p[23:8];
        end
        if (i_cmd.sumsq) begin
            r_rem <= {r_dx2 + r_dy2, 8'b0};
            r_res <= '0;
            r_bit <= 36'(1) << 34;
        end
        if (i_cmd.sqrt_step) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.mul) begin
            r_kp <= kp_p[28:13];
        end
        if (i_cmd.look) begin
            r_tabv <= w_tab[taddr];
            r_tneg <= tidx[B-1];
        end
        if (i_cmd.acc) begin
            r_sum <= r_tneg ? (r_sum - $signed({5'b0, r_tabv}))
                            : (r_sum + $signed({5'b0, r_tabv}));
        end
        if (i_cmd.nload) begin
            r_sum_neg <= r_sum[19];
            r_dq      <= 22'(abs_sum);
            r_drem    <= '0;
            r_dvs     <= (r_count == '0) ? 6'd1 : 6'(r_count);
        end
        if (i_cmd.div_step) begin
            if (drem2 >= {1'b0, r_dvs}) begin
                r_drem <= 6'(drem2 - {1'b0, r_dvs});
                r_dq   <= {r_dq[20:0], 1'b1};
            end else begin
                r_drem <= drem2[5:0];
                r_dq   <= {r_dq[20:0], 1'b0};
            end
        end
        if (i_cmd.fin) begin
            r_mag   <= mag;
            r_amp   <= r_sum_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            r_neg   <= r_sum_neg && (mag != '0);
            r_blank <= (mag25 < 20'd32768);
            r_level <= (mag[14:12] > 3'd3) ? 2'd3 : mag[13:12];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.amplitude = r_amp;
    assign o_out.blank     = r_blank;
    assign o_out.negative  = r_neg;
    assign o_out.level     = r_level;

`ifndef SYNTHESIS
    logic [MAX_SOURCES-1:0] act_vec;
    always_comb begin
        for (int s = 0; s < MAX_SOURCES; s++) begin
            act_vec[s] = r_active[s];
        end
    end
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) == $countones(act_vec)))
        else $error("active count out of step with active flags");
    a_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_mag <= 15'd16384))
        else $error("normalized magnitude above one");
    a_blank_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_level != 2'd0) |-> !r_blank)
        else $error("blank set on a nonzero level");
`endif

endmodule

`default_nettype wire

// File: design/wave_interference_field_shader.sv
`timescale 1ns / 1ps
`default_nettype none

// Interference field shader. A kind-0 word loads (enable 1) or deletes (enable 0)
// one of MAX_SOURCES point sources; a load runs a restoring divide for the
// wavenumber and then stores the source, while a delete or a slot beyond the table
// completes when the word is taken. A kind-1 word evaluates one cell and yields one
// result word: amplitude in Q1.14, blank below 0.08, sign and a level 0..3. Each
// active source is checked, squared, put through the bit-serial square root (18
// steps), multiplied, looked up and accumulated; inactive slots are only checked.
// The normalizing divide by the active count reuses the divider. Cells outside
// the grid skip the source scan. One word is processed at a time; the result
// register lets the next word be taken while a result waits.

module wave_interference_field_shader #(
    parameter int MAX_SOURCES     = wifs_pkg::MAX_SOURCES_DEF,
    parameter int GRID_COLS       = wifs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS       = wifs_pkg::GRID_ROWS_DEF,
    parameter int SINE_TABLE_BITS = wifs_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    wifs_in_if.sink    i_in,
    wifs_out_if.source o_out
);

    wifs_pkg::t_cmd    cmd;
    wifs_pkg::t_status status;

    // sequencer: source scan, sqrt and divide step counts
    wifs_ctrl #(
        .MAX_SOURCES(MAX_SOURCES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(status),
        .o_cmd   (cmd)
    );

    // source table, arithmetic and result register
    wifs_dp #(
        .MAX_SOURCES    (MAX_SOURCES),
        .GRID_COLS      (GRID_COLS),
        .GRID_ROWS      (GRID_ROWS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_status(status)
    );

endmodule

`default_nettype wire
